/* src/glls_pkg.sv */
// ----------------------------------------------------------------------------
// glls_pkg
// Shared types and constants of the greedy least-loaded scheduler.
// ----------------------------------------------------------------------------
package glls_pkg;

    // Number of machine load slots held in the load memory.
    localparam int MAX_MACHINES = 128;
    // Bits of a machine index and of a count that can hold MAX_MACHINES itself.
    localparam int IDX_W = $clog2(MAX_MACHINES);
    localparam int CNT_W = $clog2(MAX_MACHINES + 1);

    // Field widths.
    localparam int WEIGHT_W  = 32;
    localparam int LOAD_W    = 48;
    localparam int MCOUNT_W  = 8;
    localparam int MACHINE_W = 7;

    // Packed result tdata: assigned_machine, new_load, makespan, zero fill.
    localparam int RES_BITS = MACHINE_W + 2 * LOAD_W;
    localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    // Input item kinds.
    typedef enum logic {
        KIND_TASK   = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Control of the load memory.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LOAD_W-1:0] wr_data;
        logic              clear;
    } mem_ctl_t;

    // One result item handed from the sequencer to the output register.
    typedef struct packed {
        logic                 is_report;
        logic [MACHINE_W-1:0] assigned_machine;
        logic [LOAD_W-1:0]    new_load;
        logic [LOAD_W-1:0]    makespan;
    } result_t;

endpackage

/* src/glls_load_mem.sv */
// ----------------------------------------------------------------------------
// glls_load_mem
// Machine load memory: one read and one write port, registered read data,
// and one valid bit per entry so that reset and finish clear it at once.
// ----------------------------------------------------------------------------
module glls_load_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  glls_pkg::mem_ctl_t        ctl,
    output logic [glls_pkg::LOAD_W-1:0] rd_data
);
    import glls_pkg::*;

    logic [LOAD_W-1:0]       mem [MAX_MACHINES];
    logic [MAX_MACHINES-1:0] valid_reg;
    logic [LOAD_W-1:0]       rd_raw_reg;
    logic                    rd_vld_reg;

    // Storage array, written at one address per cycle.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    // Registered read of data and its valid bit.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_raw_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (ctl.rd_en) begin
            rd_vld_reg <= valid_reg[ctl.rd_addr];
        end
    end

    // Valid bits: a clear drops them all, a write marks its entry.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[ctl.wr_addr] <= 1'b1;
        end
    end

    // An entry never written since the last clear reads as zero load.
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

/* src/glls_core.sv */
// ----------------------------------------------------------------------------
// glls_core
// Sequencer and shared compare unit: scans the loads of the machines in use
// one per cycle, then updates the chosen machine or clears all loads.
// ----------------------------------------------------------------------------
module glls_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [glls_pkg::WEIGHT_W-1:0] in_weight,
    // Machines in use, already limited to MAX_MACHINES
    input  logic [glls_pkg::CNT_W-1:0]    machines,
    // Load memory
    output glls_pkg::mem_ctl_t            mem_ctl,
    input  logic [glls_pkg::LOAD_W-1:0]   mem_rd_data,
    // Result hand-off
    output logic                          res_valid,
    input  logic                          res_ready,
    output glls_pkg::result_t             res
);
    import glls_pkg::*;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [LOAD_W-1:0]   best_reg, best_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;

    logic [LOAD_W-1:0]   cmp_a;
    logic [LOAD_W-1:0]   cmp_b;
    logic                cmp_lt;
    logic                take;
    logic                last_read;
    logic [LOAD_W:0]     sum;
    logic [LOAD_W-1:0]   sum_sat;

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        weight_reg <= weight_next;
        cnt_reg    <= cnt_next;
        issue_reg  <= issue_next;
        rd_idx_reg <= rd_idx_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
    end

    // Shared comparator: a task looks for a smaller load, a finish for a
    // larger one, so the operands swap with the kind.
    always_comb begin
        cmp_a  = (kind_reg == KIND_FINISH) ? best_reg : mem_rd_data;
        cmp_b  = (kind_reg == KIND_FINISH) ? mem_rd_data : best_reg;
        cmp_lt = cmp_a < cmp_b;
        take   = cmp_lt || ((kind_reg == KIND_TASK) && (rd_idx_reg == '0));
    end

    assign last_read = rd_pend_reg && ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg);

    // Saturating add of the weight to the chosen load.
    assign sum     = {1'b0, best_reg} + (LOAD_W + 1)'(weight_reg);
    assign sum_sat = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

    // Next state and outputs.
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        weight_next  = weight_reg;
        cnt_next     = cnt_reg;
        issue_next   = issue_reg;
        rd_pend_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;

        mem_ctl         = '0;
        mem_ctl.rd_addr = issue_reg[IDX_W-1:0];
        mem_ctl.wr_addr = pick_reg;
        mem_ctl.wr_data = sum_sat;

        res.is_report        = (kind_reg == KIND_FINISH);
        res.assigned_machine = (kind_reg == KIND_FINISH) ? '0 : MACHINE_W'(pick_reg);
        res.new_load         = (kind_reg == KIND_FINISH) ? '0 : best_reg;
        res.makespan         = (kind_reg == KIND_FINISH) ? best_reg : '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next   = kind_t'(in_kind);
                    weight_next = in_weight;
                    cnt_next    = machines;
                    issue_next  = '0;
                    best_next   = '0;
                    pick_next   = '0;
                    if (machines == '0) begin
                        // No machines: nothing to scan, a finish still clears.
                        mem_ctl.clear = (kind_t'(in_kind) == KIND_FINISH);
                        state_next    = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle while machines remain.
                if (issue_reg < cnt_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                // Compare the load returned from the previous read.
                if (rd_pend_reg && take) begin
                    best_next = mem_rd_data;
                    pick_next = rd_idx_reg;
                end
                if (last_read) begin
                    if (kind_reg == KIND_FINISH) begin
                        mem_ctl.clear = 1'b1;
                        state_next    = ST_RESULT;
                    end else begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE: begin
                mem_ctl.wr_en = 1'b1;
                best_next     = sum_sat;
                state_next    = ST_RESULT;
            end

            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/greedy_least_loaded_scheduler.sv */
// Sequence: a task item passes the scan, update and result states, a finish item
// scan and result, and only result when M is zero (M = machine_count limited to 128).
// Rate: the scan reads one load per cycle; a new item is taken only back in idle,
// after the result has gone to the output register, so output stalls hold the flow.
// Reset: synchronous active-low aresetn clears all loads at once (valid bits),
// sets machine_count to 1 and empties the output register.
// ----------------------------------------------------------------------------
// greedy_least_loaded_scheduler
// Greedy list scheduler: each task goes to the least loaded machine, a
// finish item reports the makespan and clears all loads.
// ----------------------------------------------------------------------------
module greedy_least_loaded_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel: machine_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glls_pkg::MCOUNT_W-1:0]     cfg_data,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [glls_pkg::WEIGHT_W-1:0]     s_tdata,   // [31:0] weight
    input  logic                              s_tuser,   // [0] kind
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] assigned_machine, [54:7] new_load, [102:55] makespan, [103] zero
    output logic [glls_pkg::RES_TDATA_W-1:0]  m_tdata,
    output logic                              m_tuser    // [0] is_report
);
    import glls_pkg::*;

    logic [MCOUNT_W-1:0] mcount_reg;
    logic [CNT_W-1:0]    machines;
    mem_ctl_t            mem_ctl;
    logic [LOAD_W-1:0]   mem_rd_data;
    logic                res_valid;
    logic                res_ready;
    result_t             res;
    logic                m_tvalid_reg, m_tvalid_next;
    result_t             out_reg;

    // Configuration register, written on any transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcount_reg <= MCOUNT_W'(1);
        end else if (cfg_valid) begin
            mcount_reg <= cfg_data;
        end
    end

    // Machines in use, limited to the number of load slots.
    assign machines = (32'(mcount_reg) > MAX_MACHINES) ? CNT_W'(MAX_MACHINES)
                                                       : CNT_W'(mcount_reg);

    glls_load_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .rd_data (mem_rd_data)
    );

    glls_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_weight   (s_tdata),
        .machines    (machines),
        .mem_ctl     (mem_ctl),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: takes a result when empty or when its transfer completes.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.is_report;
    assign m_tdata  = RES_TDATA_W'({out_reg.makespan, out_reg.new_load,
                                   out_reg.assigned_machine});

endmodule
